// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, quiet in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bstr_pkg.sv =====
// ---------------------------------------------------------------------------
// bstr_pkg
// types and constants shared by the beat slice time remapper
// ---------------------------------------------------------------------------
package bstr_pkg;

  localparam int FW  = 14;  // frame index
  localparam int SW  = 16;  // sample
  localparam int MW  = 3;   // remap mode
  localparam int LW  = 16;  // slice length
  localparam int NCW = 9;   // slice count
  localparam int CLW = 15;  // clip length
  localparam int KW  = 12;  // 7*k+3
  localparam int TW  = 25;  // slice count times slice length
  localparam int CIW = 2;   // config index
  localparam int CDW = 16;  // config data

  localparam logic [MW-1:0] MODE_FWD  = 3'd0;
  localparam logic [MW-1:0] MODE_REV  = 3'd1;
  localparam logic [MW-1:0] MODE_STUT = 3'd2;
  localparam logic [MW-1:0] MODE_SHUF = 3'd3;
  localparam logic [MW-1:0] MODE_HALF = 3'd4;
  localparam logic [MW-1:0] MODE_DBL  = 3'd5;

  localparam logic [CIW-1:0] REG_MODE = 2'd0;
  localparam logic [CIW-1:0] REG_SLEN = 2'd1;
  localparam logic [CIW-1:0] REG_SCNT = 2'd2;
  localparam logic [CIW-1:0] REG_CLIP = 2'd3;

  localparam logic [MW-1:0]  RST_MODE = MODE_FWD;
  localparam logic [LW-1:0]  RST_SLEN = 16'd24000;
  localparam logic [NCW-1:0] RST_SCNT = 9'd1;
  localparam logic [CLW-1:0] RST_CLIP = 15'd16384;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic [MW-1:0]  mode;
    logic [LW-1:0]  slen;
    logic [NCW-1:0] scnt;
    logic [CLW-1:0] clip;
  } cfg_t;

  typedef struct packed {
    logic          rd;
    logic          wr_ok;
    logic          ch_ok;
    logic [FW-1:0] idx;
    logic          ch;
    logic [SW-1:0] smp;
  } item_t;

endpackage

// ===== sv/beat_slice_time_remapper_unit.sv =====
// ---------------------------------------------------------------------------
// beat_slice_time_remapper_unit
// beat slice time remapper: clip store with remapped, interpolated reads
// ---------------------------------------------------------------------------
// channel | handshake            | payload
// in      | start / busy         | req_type, frame_index, channel, sample_in
// out     | out_valid strobe     | sample_out, source_frame, half_step
// cfg     | cfg_we               | cfg_index, cfg_wdata
//
// one beat accepted per clock; a read's strobe follows the accepting edge through
// three bit-per-stage dividers (wrap, slice split, shuffle) plus remap, clamp and
// the registered store read.
// loads write the store in beat order at the store stage, so later reads see them.
// busy never rises: the back end takes the queue head every clock; results cannot be held off.
// synchronous active low reset loads register reset values and clears valid flags;
// store is not cleared.
// ---------------------------------------------------------------------------
module beat_slice_time_remapper_unit #(
  parameter int MAX_FRAMES      = 16384,
  parameter int CHANNELS        = 2,
  parameter int MAX_SLICE_COUNT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [bstr_pkg::FW-1:0]        in_frame_index,
  input  logic                           in_channel,
  input  logic signed [bstr_pkg::SW-1:0] in_sample_in,
  input  logic                           cfg_we,
  input  logic [bstr_pkg::CIW-1:0]       cfg_index,
  input  logic [bstr_pkg::CDW-1:0]       cfg_wdata,
  output logic                           out_valid,
  output logic signed [bstr_pkg::SW-1:0] out_sample_out,
  output logic [bstr_pkg::FW-1:0]        out_source_frame,
  output logic                           out_half_step
);
  import bstr_pkg::*;

  cfg_t  cfg_r;
  logic  head_vld;
  item_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= RST_MODE;
      cfg_r.slen <= RST_SLEN;
      cfg_r.scnt <= RST_SCNT;
      cfg_r.clip <= RST_CLIP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: cfg_r.mode <= cfg_wdata[MW-1:0];
        REG_SLEN: cfg_r.slen <= cfg_wdata[LW-1:0];
        REG_SCNT: cfg_r.scnt <= cfg_wdata[NCW-1:0];
        REG_CLIP: cfg_r.clip <= cfg_wdata[CLW-1:0];
      endcase
    end
  end

  bstr_front #(
    .MAX_FRAMES (MAX_FRAMES),
    .CHANNELS   (CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_frame_index (in_frame_index),
    .in_channel     (in_channel),
    .in_sample_in   (in_sample_in),
    .head_vld       (head_vld),
    .head           (head)
  );

  bstr_back #(
    .MAX_FRAMES      (MAX_FRAMES),
    .CHANNELS        (CHANNELS),
    .MAX_SLICE_COUNT (MAX_SLICE_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head_vld         (head_vld),
    .head             (head),
    .out_valid        (out_valid),
    .out_sample_out   (out_sample_out),
    .out_source_frame (out_source_frame),
    .out_half_step    (out_half_step)
  );
endmodule

// ===== sv/bstr_ram.sv =====
// ---------------------------------------------------------------------------
// bstr_ram
// generic ram, one write port, two registered read ports
// ---------------------------------------------------------------------------
module bstr_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [DW-1:0]            rdata0,
  output logic [DW-1:0]            rdata1
);
  logic [DW-1:0] mem [0:DEPTH-1];
  logic [DW-1:0] rdata0_r;
  logic [DW-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;
endmodule

// ===== sv/bstr_div.sv =====
// ---------------------------------------------------------------------------
// bstr_div
// pipelined restoring divider, one quotient bit per stage, NW stages
// ---------------------------------------------------------------------------
module bstr_div #(
  parameter int NW = 14,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [NW-1:0] rem
);
  localparam int CW = (NW + 1 > DW) ? NW + 1 : DW;

  logic [NW-1:0] num_r [0:NW-2];
  logic [DW-1:0] den_r [0:NW-2];
  logic [NW-1:0] quo_r [0:NW-1];
  logic [NW-1:0] rem_r [0:NW-1];

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [NW-1:0] num_i;
    logic [NW-1:0] quo_i;
    logic [NW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [CW-1:0] part;
    logic [CW-1:0] dz;
    logic          ge;

    if (s == 0) begin : g_first
      assign num_i = num;
      assign den_i = den;
      assign quo_i = '0;
      assign rem_i = '0;
    end else begin : g_next
      assign num_i = num_r[s-1];
      assign den_i = den_r[s-1];
      assign quo_i = quo_r[s-1];
      assign rem_i = rem_r[s-1];
    end

    // bring down the next dividend bit
    assign part = CW'({rem_i, num_i[NW-1-s]});
    assign dz   = CW'(den_i);
    assign ge   = part >= dz;

    always_ff @(posedge clk) begin
      quo_r[s] <= NW'({quo_i, ge});
      rem_r[s] <= ge ? NW'(part - dz) : NW'(part);
    end

    if (s < NW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        num_r[s] <= num_i;
        den_r[s] <= den_i;
      end
    end
  end

  assign quo = quo_r[NW-1];
  assign rem = rem_r[NW-1];
endmodule

// ===== sv/bstr_front.sv =====
// ---------------------------------------------------------------------------
// bstr_front
// accepts beats, classifies them and holds them in a two entry queue
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bstr_front #(
  parameter int MAX_FRAMES = 16384,
  parameter int CHANNELS   = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_req_type,
  input  logic [bstr_pkg::FW-1:0] in_frame_index,
  input  logic                    in_channel,
  input  logic [bstr_pkg::SW-1:0] in_sample_in,
  output logic                    head_vld,
  output bstr_pkg::item_t         head
);
  import bstr_pkg::*;

  item_t      q_r [0:1];
  logic       wp_r;
  logic       wp_nxt;
  logic       rp_r;
  logic       rp_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;
  item_t      cls;

  assign busy     = (cnt_r == 2'd2);
  assign push     = start && !busy;
  // back end never stalls, so the head leaves every cycle
  assign pop      = (cnt_r != 2'd0);
  assign head_vld = pop;
  assign head     = q_r[rp_r];

  always_comb begin
    cls.rd    = (in_req_type == REQ_READ);
    cls.ch_ok = (32'(in_channel) < CHANNELS);
    cls.wr_ok = cls.ch_ok && (32'(in_frame_index) < MAX_FRAMES);
    cls.idx   = in_frame_index;
    cls.ch    = in_channel;
    cls.smp   = in_sample_in;
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  `ASSERT_CLK(a_cnt_range, cnt_r <= 2'd2, "queue count out of range")
  `ASSERT_NEXT(a_push_only, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "push lost in queue")
endmodule

// ===== sv/bstr_back.sv =====
// ---------------------------------------------------------------------------
// bstr_back
// wrap, slice split and remap pipeline, clip store and interpolation
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bstr_back #(
  parameter int MAX_FRAMES      = 16384,
  parameter int CHANNELS        = 2,
  parameter int MAX_SLICE_COUNT = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bstr_pkg::cfg_t                 cfg,
  input  logic                           head_vld,
  input  bstr_pkg::item_t                head,
  output logic                           out_valid,
  output logic signed [bstr_pkg::SW-1:0] out_sample_out,
  output logic [bstr_pkg::FW-1:0]        out_source_frame,
  output logic                           out_half_step
);
  import bstr_pkg::*;

  localparam int DEPTH = MAX_FRAMES * CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int P_D2  = 2 * FW;
  localparam int P_M1  = P_D2 + 1;
  localparam int P_D3  = P_M1 + KW;
  localparam int P_M2  = P_D3 + 1;
  localparam int P_M3  = P_M2 + 1;
  localparam int P_RD  = P_M3 + 1;

  logic [P_RD:0] vld_r;
  item_t         itm_r [0:P_RD];

  // config derived values; the user must see that config only moves while idle, the block does not enforce it
  logic [NCW-1:0] n_c;
  logic [TW-1:0]  tot_c;
  logic           bypass_c;
  logic [CLW-1:0] clip_c;
  logic [CLW-1:0] maxs_c;

  always_comb begin
    n_c      = (32'(cfg.scnt) > MAX_SLICE_COUNT) ? NCW'(MAX_SLICE_COUNT) : cfg.scnt;
    tot_c    = TW'(n_c) * TW'(cfg.slen);
    bypass_c = (cfg.scnt == '0) || (cfg.slen == '0);
    if (cfg.clip < CLW'(2)) begin
      clip_c = CLW'(2);
    end else if (32'(cfg.clip) > MAX_FRAMES) begin
      clip_c = CLW'(MAX_FRAMES);
    end else begin
      clip_c = cfg.clip;
    end
    maxs_c = clip_c - CLW'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[P_RD-1:0], head_vld};
    end
  end

  always_ff @(posedge clk) begin
    itm_r[0] <= head;
    for (int i = 1; i <= P_RD; i++) begin
      itm_r[i] <= itm_r[i-1];
    end
  end

  // w = index mod total
  logic [FW-1:0] w_d1;
  bstr_div #(.NW(FW), .DW(TW)) u_wrap (
    .clk (clk),
    .num (itm_r[0].idx),
    .den (tot_c),
    .quo (),
    .rem (w_d1)
  );

  // k = w / len, o = w mod len
  logic [FW-1:0] k_d2;
  logic [FW-1:0] o_d2;
  bstr_div #(.NW(FW), .DW(LW)) u_slice (
    .clk (clk),
    .num (w_d1),
    .den (cfg.slen),
    .quo (k_d2),
    .rem (o_d2)
  );

  logic [NCW-1:0] k9;
  logic [LW:0]    st2;
  logic [LW-1:0]  st_c;
  logic [KW-1:0]  m1_k7_r;
  logic [TW-1:0]  m1_kl_r;
  logic [FW-1:0]  m1_o_r;
  logic [LW-1:0]  m1_st_r;

  always_comb begin
    k9   = k_d2[NCW-1:0];
    st2  = (LW+1)'({o_d2, 1'b0});
    // stutter offset: 2*o is below twice the slice length
    st_c = (st2 >= (LW+1)'(cfg.slen)) ? LW'(st2 - (LW+1)'(cfg.slen)) : LW'(st2);
  end

  always_ff @(posedge clk) begin
    m1_k7_r <= KW'(KW'(k9) * KW'(7) + KW'(3));
    m1_kl_r <= TW'(k9) * TW'(cfg.slen);
    m1_o_r  <= o_d2;
    m1_st_r <= st_c;
  end

  // shuffled slice = (7*k+3) mod n
  logic [KW-1:0] sh_d3;
  bstr_div #(.NW(KW), .DW(NCW)) u_shuf (
    .clk (clk),
    .num (m1_k7_r),
    .den (n_c),
    .quo (),
    .rem (sh_d3)
  );

  logic [TW-1:0] dl_kl_r [0:KW-1];
  logic [FW-1:0] dl_o_r  [0:KW-1];
  logic [LW-1:0] dl_st_r [0:KW-1];

  always_ff @(posedge clk) begin
    dl_kl_r[0] <= m1_kl_r;
    dl_o_r[0]  <= m1_o_r;
    dl_st_r[0] <= m1_st_r;
    for (int i = 1; i < KW; i++) begin
      dl_kl_r[i] <= dl_kl_r[i-1];
      dl_o_r[i]  <= dl_o_r[i-1];
      dl_st_r[i] <= dl_st_r[i-1];
    end
  end

  logic [FW-1:0] m2_w_r;
  logic [TW-1:0] m2_stut_r;
  logic [TW-1:0] m2_shuf_r;

  always_ff @(posedge clk) begin
    m2_w_r    <= FW'(dl_kl_r[KW-1] + TW'(dl_o_r[KW-1]));
    m2_stut_r <= dl_kl_r[KW-1] + TW'(dl_st_r[KW-1]);
    m2_shuf_r <= TW'(sh_d3[NCW-1:0]) * TW'(cfg.slen) + TW'(dl_o_r[KW-1]);
  end

  logic [TW-1:0] pos_c;
  logic          half_c;
  logic [TW-1:0] m3_pos_r;
  logic          m3_half_r;

  always_comb begin
    pos_c  = TW'(m2_w_r);
    half_c = 1'b0;
    if (bypass_c) begin
      pos_c = TW'(itm_r[P_M2].idx);
    end else begin
      unique case (cfg.mode)
        MODE_REV:  pos_c = tot_c - TW'(m2_w_r);
        MODE_STUT: pos_c = m2_stut_r;
        MODE_SHUF: pos_c = m2_shuf_r;
        MODE_HALF: begin
          pos_c  = TW'(m2_w_r >> 1);
          half_c = m2_w_r[0];
        end
        MODE_DBL:  pos_c = TW'({m2_w_r, 1'b0});
        default:   pos_c = TW'(m2_w_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    m3_pos_r  <= pos_c;
    m3_half_r <= half_c;
  end

  // clamp, then address the store; loads write here in beat order
  logic [CLW-1:0] s_c;
  logic [AW-1:0]  ra0_c;
  logic [AW-1:0]  ra1_c;
  logic [AW-1:0]  wa_c;
  logic           we_c;
  logic [SW-1:0]  rd0;
  logic [SW-1:0]  rd1;

  always_comb begin
    s_c   = (m3_pos_r > TW'(maxs_c)) ? maxs_c : CLW'(m3_pos_r);
    ra0_c = AW'(32'(s_c) * CHANNELS + 32'(itm_r[P_M3].ch));
    ra1_c = AW'((32'(s_c) + 32'd1) * CHANNELS + 32'(itm_r[P_M3].ch));
    wa_c  = AW'(32'(itm_r[P_M3].idx) * CHANNELS + 32'(itm_r[P_M3].ch));
    we_c  = vld_r[P_M3] && !itm_r[P_M3].rd && itm_r[P_M3].wr_ok;
  end

  bstr_ram #(.DW(SW), .DEPTH(DEPTH)) u_store (
    .clk    (clk),
    .we     (we_c),
    .waddr  (wa_c),
    .wdata  (itm_r[P_M3].smp),
    .raddr0 (ra0_c),
    .raddr1 (ra1_c),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  logic [CLW-1:0] rd_s_r;
  logic           rd_half_r;

  always_ff @(posedge clk) begin
    rd_s_r    <= s_c;
    rd_half_r <= m3_half_r;
  end

  logic signed [SW:0]   sum_c;
  logic signed [SW-1:0] val_c;
  logic                 out_vld_r;
  logic signed [SW-1:0] out_smp_r;
  logic [FW-1:0]        out_src_r;
  logic                 out_half_r;

  always_comb begin
    sum_c = $signed({rd0[SW-1], rd0}) + $signed({rd1[SW-1], rd1});
    if (!itm_r[P_RD].ch_ok) begin
      val_c = '0;
    end else if (rd_half_r) begin
      // dropping the low bit floors toward minus infinity
      val_c = sum_c[SW:1];
    end else begin
      val_c = $signed(rd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[P_RD] && itm_r[P_RD].rd;
    end
  end

  always_ff @(posedge clk) begin
    out_smp_r  <= val_c;
    out_src_r  <= FW'(rd_s_r);
    out_half_r <= rd_half_r;
  end

  assign out_valid        = out_vld_r;
  assign out_sample_out   = out_smp_r;
  assign out_source_frame = out_src_r;
  assign out_half_step    = out_half_r;

  `ASSERT_NEXT(a_read_out, vld_r[P_RD] && itm_r[P_RD].rd, out_vld_r, "read beat dropped")
  `ASSERT_NEXT(a_no_ghost, !(vld_r[P_RD] && itm_r[P_RD].rd), !out_vld_r, "result without read")
endmodule
